[design/fvn_pkg.sv]
// Shared constants, register codes, hash table and control types for the fractal noise block.
package fvn_pkg;

	localparam int MAX_OCTAVES_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int HASH_ENTRIES    = 256;
	localparam int HASH_BITS       = 8;
	localparam int COORD_W         = 32;
	localparam int FREQ_W          = 24;
	localparam int FREQ_FRAC       = 16;
	localparam int OCT_CNT_W       = 6;
	localparam int SEED_W          = 8;
	localparam int OUT_W           = 16;
	localparam int OCT_W           = 7;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 24;

	localparam logic [CFG_IDX_W-1:0] REG_FREQUENCY    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEED         = 2'd2;

	localparam logic [FREQ_W-1:0]    FREQ_RESET   = 24'd3277;
	localparam logic [OCT_CNT_W-1:0] OCT_RESET    = 6'd30;
	localparam logic [SEED_W-1:0]    SEED_RESET   = 8'd0;
	localparam logic [OUT_W-1:0]     OUT_MAX      = 16'd65280;

	typedef struct packed {
		logic              en;
		logic [SEED_W-1:0] seed;
		logic [OCT_W-1:0]  depth;
	} cell_ctl_t;

	localparam logic [HASH_BITS-1:0] PERM [HASH_ENTRIES] = '{
		8'd208,8'd34,8'd231,8'd213,8'd32,8'd248,8'd233,8'd56,8'd161,8'd78,8'd24,8'd140,
		8'd71,8'd48,8'd140,8'd254,8'd245,8'd255,8'd247,8'd247,8'd40,8'd185,8'd248,8'd251,
		8'd245,8'd28,8'd124,8'd204,8'd204,8'd76,8'd36,8'd1,8'd107,8'd28,8'd234,8'd163,
		8'd202,8'd224,8'd245,8'd128,8'd167,8'd204,8'd9,8'd92,8'd217,8'd54,8'd239,8'd174,
		8'd173,8'd102,8'd193,8'd189,8'd190,8'd121,8'd100,8'd108,8'd167,8'd44,8'd43,8'd77,
		8'd180,8'd204,8'd8,8'd81,8'd70,8'd223,8'd11,8'd38,8'd24,8'd254,8'd210,8'd210,
		8'd177,8'd32,8'd81,8'd195,8'd243,8'd125,8'd8,8'd169,8'd112,8'd32,8'd97,8'd53,
		8'd195,8'd13,8'd203,8'd9,8'd47,8'd104,8'd125,8'd117,8'd114,8'd124,8'd165,8'd203,
		8'd181,8'd235,8'd193,8'd206,8'd70,8'd180,8'd174,8'd0,8'd167,8'd181,8'd41,8'd164,
		8'd30,8'd116,8'd127,8'd198,8'd245,8'd146,8'd87,8'd224,8'd149,8'd206,8'd57,8'd4,
		8'd192,8'd210,8'd65,8'd210,8'd129,8'd240,8'd178,8'd105,8'd228,8'd108,8'd245,8'd148,
		8'd140,8'd40,8'd35,8'd195,8'd38,8'd58,8'd65,8'd207,8'd215,8'd253,8'd65,8'd85,
		8'd208,8'd76,8'd62,8'd3,8'd237,8'd55,8'd89,8'd232,8'd50,8'd217,8'd64,8'd244,
		8'd157,8'd199,8'd121,8'd252,8'd90,8'd17,8'd212,8'd203,8'd149,8'd152,8'd140,8'd187,
		8'd234,8'd177,8'd73,8'd174,8'd193,8'd100,8'd192,8'd143,8'd97,8'd53,8'd145,8'd135,
		8'd19,8'd103,8'd13,8'd90,8'd135,8'd151,8'd199,8'd91,8'd239,8'd247,8'd33,8'd39,
		8'd145,8'd101,8'd120,8'd99,8'd3,8'd186,8'd86,8'd99,8'd41,8'd237,8'd203,8'd111,
		8'd79,8'd220,8'd135,8'd158,8'd42,8'd30,8'd154,8'd120,8'd67,8'd87,8'd167,8'd135,
		8'd176,8'd183,8'd191,8'd253,8'd115,8'd184,8'd21,8'd233,8'd58,8'd129,8'd233,8'd142,
		8'd39,8'd128,8'd211,8'd118,8'd137,8'd139,8'd255,8'd114,8'd20,8'd218,8'd113,8'd154,
		8'd27,8'd127,8'd246,8'd250,8'd1,8'd8,8'd198,8'd250,8'd209,8'd92,8'd222,8'd173,
		8'd21,8'd88,8'd102,8'd219
	};

endpackage

[design/fvn_if.sv]
// Point and noise channel interfaces.
interface fvn_point_if;
	logic                        valid;
	logic                        ready;
	logic [fvn_pkg::COORD_W-1:0] coord_x;
	logic [fvn_pkg::COORD_W-1:0] coord_y;
	modport source(output valid, coord_x, coord_y, input ready);
	modport sink(input valid, coord_x, coord_y, output ready);
endinterface

interface fvn_noise_if;
	logic                      valid;
	logic                      ready;
	logic [fvn_pkg::OUT_W-1:0] noise_value;
	modport source(output valid, noise_value, input ready);
	modport sink(input valid, noise_value, output ready);
endinterface

[design/fvn_octave_cell.sv]
// One octave of value noise: hash, smoothstep, blend and accumulate, four stages.
module fvn_octave_cell #(
	parameter int FRAC_BITS = fvn_pkg::FRAC_BITS_DEF,
	parameter int OCTAVE = 0,
	localparam int PW = FRAC_BITS + 8,
	localparam int FINW = FRAC_BITS + 9,
	localparam int AMPW = FRAC_BITS + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fvn_pkg::cell_ctl_t ctl,
	input  logic              in_valid,
	input  logic [PW-1:0]     in_px,
	input  logic [PW-1:0]     in_py,
	input  logic [FINW-1:0]   in_fin,
	input  logic [AMPW-1:0]   in_amp,
	output logic              out_valid,
	output logic [PW-1:0]     out_px,
	output logic [PW-1:0]     out_py,
	output logic [FINW-1:0]   out_fin,
	output logic [AMPW-1:0]   out_amp
);
	localparam int F = FRAC_BITS;
	localparam logic [F+1:0] THREE_ONE = (F+2)'(3) << F;
	localparam logic [AMPW-1:0] AMP_STEP = AMPW'((64'd1 << F) >> OCTAVE);

	// stage 1: row lookups, squared fractions
	logic [7:0]     ix, iy;
	logic [F-1:0]   fx, fy;
	logic [2*F-1:0] fx_sq, fy_sq;
	logic           v_s1;
	logic [7:0]     ix_s1, row0_s1, row1_s1;
	logic [F-1:0]   fx_s1, fy_s1, fx2_s1, fy2_s1;
	logic [PW-1:0]  px_s1, py_s1;
	logic [FINW-1:0] fin_s1;
	logic [AMPW-1:0] amp_s1;

	assign ix = in_px[PW-1:F];
	assign iy = in_py[PW-1:F];
	assign fx = in_px[F-1:0];
	assign fy = in_py[F-1:0];
	assign fx_sq = fx * fx;
	assign fy_sq = fy * fy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ctl.en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			ix_s1   <= ix;
			row0_s1 <= fvn_pkg::PERM[8'(iy + ctl.seed)];
			row1_s1 <= fvn_pkg::PERM[8'(iy + 8'd1 + ctl.seed)];
			fx_s1   <= fx;
			fy_s1   <= fy;
			fx2_s1  <= fx_sq[2*F-1:F];
			fy2_s1  <= fy_sq[2*F-1:F];
			px_s1   <= in_px;
			py_s1   <= in_py;
			fin_s1  <= in_fin;
			amp_s1  <= in_amp;
		end
	end

	// stage 2: corner bytes, smoothstep weights
	logic [2*F+1:0] wx_full, wy_full;
	logic           v_s2;
	logic [7:0]     c00_s2, c10_s2, c01_s2, c11_s2;
	logic [F-1:0]   wx_s2, wy_s2;
	logic [PW-1:0]  px_s2, py_s2;
	logic [FINW-1:0] fin_s2;
	logic [AMPW-1:0] amp_s2;

	assign wx_full = fx2_s1 * (THREE_ONE - {1'b0, fx_s1, 1'b0});
	assign wy_full = fy2_s1 * (THREE_ONE - {1'b0, fy_s1, 1'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ctl.en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			c00_s2 <= fvn_pkg::PERM[8'(row0_s1 + ix_s1)];
			c10_s2 <= fvn_pkg::PERM[8'(row0_s1 + ix_s1 + 8'd1)];
			c01_s2 <= fvn_pkg::PERM[8'(row1_s1 + ix_s1)];
			c11_s2 <= fvn_pkg::PERM[8'(row1_s1 + ix_s1 + 8'd1)];
			wx_s2  <= wx_full[2*F-1:F];
			wy_s2  <= wy_full[2*F-1:F];
			px_s2  <= px_s1;
			py_s2  <= py_s1;
			fin_s2 <= fin_s1;
			amp_s2 <= amp_s1;
		end
	end

	// stage 3: blend along x as a*ONE + (b-a)*w
	logic signed [8:0]    dlo, dhi;
	logic signed [F+9:0]  lo_full, hi_full;
	logic           v_s3;
	logic [PW-1:0]  lo_s3, hi_s3;
	logic [F-1:0]   wy_s3;
	logic [PW-1:0]  px_s3, py_s3;
	logic [FINW-1:0] fin_s3;
	logic [AMPW-1:0] amp_s3;

	assign dlo = $signed({1'b0, c10_s2}) - $signed({1'b0, c00_s2});
	assign dhi = $signed({1'b0, c11_s2}) - $signed({1'b0, c01_s2});
	assign lo_full = $signed({2'b00, c00_s2, F'(0)}) + dlo * $signed({1'b0, wx_s2});
	assign hi_full = $signed({2'b00, c01_s2, F'(0)}) + dhi * $signed({1'b0, wx_s2});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (ctl.en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			lo_s3  <= lo_full[PW-1:0];
			hi_s3  <= hi_full[PW-1:0];
			wy_s3  <= wy_s2;
			px_s3  <= px_s2;
			py_s3  <= py_s2;
			fin_s3 <= fin_s2;
			amp_s3 <= amp_s2;
		end
	end

	// stage 4: blend along y, weight by octave, accumulate, double the point
	logic signed [PW:0]      dy;
	logic signed [2*F+9:0]   n_full;
	logic [PW-1:0]           n_val;
	logic                    active;
	logic           v_s4;
	logic [PW-1:0]  px_s4, py_s4;
	logic [FINW-1:0] fin_s4;
	logic [AMPW-1:0] amp_s4;

	assign dy = $signed({1'b0, hi_s3}) - $signed({1'b0, lo_s3});
	assign n_full = $signed({2'b00, lo_s3, F'(0)}) + dy * $signed({1'b0, wy_s3});
	assign n_val = n_full[2*F+7:F];
	assign active = OCTAVE < int'(ctl.depth);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (ctl.en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			px_s4  <= {px_s3[PW-2:0], 1'b0};
			py_s4  <= {py_s3[PW-2:0], 1'b0};
			fin_s4 <= active ? fin_s3 + FINW'(n_val >> OCTAVE) : fin_s3;
			amp_s4 <= active ? amp_s3 + AMP_STEP : amp_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_px    = px_s4;
	assign out_py    = py_s4;
	assign out_fin   = fin_s4;
	assign out_amp   = amp_s4;
endmodule

[design/fvn_div_cell.sv]
// One restoring-division step: settles one quotient bit per stage.
module fvn_div_cell #(
	parameter int FRAC_BITS = fvn_pkg::FRAC_BITS_DEF,
	parameter int QBIT = 0,
	localparam int NW = FRAC_BITS + 25,
	localparam int DW = FRAC_BITS + 9
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [NW-1:0]            in_rem,
	input  logic [DW-1:0]            in_den,
	input  logic [fvn_pkg::OUT_W-1:0] in_quo,
	input  logic                     in_zero,
	output logic                     out_valid,
	output logic [NW-1:0]            out_rem,
	output logic [DW-1:0]            out_den,
	output logic [fvn_pkg::OUT_W-1:0] out_quo,
	output logic                     out_zero
);
	localparam logic [fvn_pkg::OUT_W-1:0] QMASK = {{(fvn_pkg::OUT_W-1){1'b0}}, 1'b1} << QBIT;

	logic [NW-1:0] shifted;
	logic          fits;
	logic          v_s1;
	logic [NW-1:0] rem_s1;
	logic [DW-1:0] den_s1;
	logic [fvn_pkg::OUT_W-1:0] quo_s1;
	logic          zero_s1;

	assign shifted = NW'(in_den) << QBIT;
	assign fits = in_rem >= shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1  <= fits ? in_rem - shifted : in_rem;
			den_s1  <= in_den;
			quo_s1  <= fits ? (in_quo | QMASK) : in_quo;
			zero_s1 <= in_zero;
		end
	end

	assign out_valid = v_s1;
	assign out_rem   = rem_s1;
	assign out_den   = den_s1;
	assign out_quo   = quo_s1;
	assign out_zero  = zero_s1;
endmodule

[design/fractal_value_noise_2d.sv]
// Fractal 2-D value noise: takes one Q16.16 point per cycle unless stalled, returns Q0.16 noise.
// A point enters every clock unless the input stalls. Each point passes the input scaling
// register, the row of four-stage octave cells, the sixteen-stage quotient pipeline behind
// it and the output register. The octave count register selects how many cells add into
// the sum; the others pass the item through. A two-entry output buffer lets the pipeline
// keep taking points while one result waits; the input stalls only when both entries are
// full. Write registers only while idle.
module fractal_value_noise_2d #(
	parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF,
	parameter int FRAC_BITS = fvn_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	fvn_point_if.sink                     point,
	fvn_noise_if.source                   noise,
	input  logic                          cfg_we,
	input  logic [fvn_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fvn_pkg::CFG_DATA_W-1:0] cfg_data
);
	localparam int F = FRAC_BITS;
	localparam int PW = F + 8;
	localparam int FINW = F + 9;
	localparam int AMPW = F + 1;
	localparam int NW = F + 25;
	localparam int DW = F + 9;
	localparam int QW = fvn_pkg::OUT_W;
	localparam int PRODW = fvn_pkg::COORD_W + fvn_pkg::FREQ_W;

	// configuration
	logic [fvn_pkg::FREQ_W-1:0]    freq_q;
	logic [fvn_pkg::OCT_CNT_W-1:0] oct_q;
	logic [fvn_pkg::SEED_W-1:0]    seed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= fvn_pkg::FREQ_RESET;
			oct_q  <= fvn_pkg::OCT_RESET;
			seed_q <= fvn_pkg::SEED_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				fvn_pkg::REG_FREQUENCY:    freq_q <= cfg_data[fvn_pkg::FREQ_W-1:0];
				fvn_pkg::REG_OCTAVE_COUNT: oct_q  <= cfg_data[fvn_pkg::OCT_CNT_W-1:0];
				fvn_pkg::REG_SEED:         seed_q <= cfg_data[fvn_pkg::SEED_W-1:0];
				default: ;
			endcase
		end
	end

	logic               en;
	logic               skid_valid_q;
	logic               out_valid_q;
	logic [fvn_pkg::OCT_W-1:0] depth_sat;
	fvn_pkg::cell_ctl_t ctl;

	assign en = !skid_valid_q;
	assign point.ready = en;
	assign depth_sat = ({1'b0, oct_q} > fvn_pkg::OCT_W'(MAX_OCTAVES))
		? fvn_pkg::OCT_W'(MAX_OCTAVES) : {1'b0, oct_q};
	assign ctl = '{en: en, seed: seed_q, depth: depth_sat};

	// scale the point by the frequency
	logic [PRODW-1:0] prod_x, prod_y;
	logic             v_s1;
	logic [PW-1:0]    px_s1, py_s1;

	assign prod_x = point.coord_x * freq_q;
	assign prod_y = point.coord_y * freq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= point.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= prod_x[fvn_pkg::FREQ_FRAC+PW-1:fvn_pkg::FREQ_FRAC];
			py_s1 <= prod_y[fvn_pkg::FREQ_FRAC+PW-1:fvn_pkg::FREQ_FRAC];
		end
	end

	// octave cells
	logic            oc_v   [MAX_OCTAVES+1];
	logic [PW-1:0]   oc_px  [MAX_OCTAVES+1];
	logic [PW-1:0]   oc_py  [MAX_OCTAVES+1];
	logic [FINW-1:0] oc_fin [MAX_OCTAVES+1];
	logic [AMPW-1:0] oc_amp [MAX_OCTAVES+1];

	assign oc_v[0]   = v_s1;
	assign oc_px[0]  = px_s1;
	assign oc_py[0]  = py_s1;
	assign oc_fin[0] = '0;
	assign oc_amp[0] = '0;

	for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
		fvn_octave_cell #(.FRAC_BITS(F), .OCTAVE(k)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.in_valid (oc_v[k]),
			.in_px    (oc_px[k]),
			.in_py    (oc_py[k]),
			.in_fin   (oc_fin[k]),
			.in_amp   (oc_amp[k]),
			.out_valid(oc_v[k+1]),
			.out_px   (oc_px[k+1]),
			.out_py   (oc_py[k+1]),
			.out_fin  (oc_fin[k+1]),
			.out_amp  (oc_amp[k+1])
		);
	end

	// normalize: (fin << 16) / (amp << 8), one quotient bit per stage
	logic          dv_v    [QW+1];
	logic [NW-1:0] dv_rem  [QW+1];
	logic [DW-1:0] dv_den  [QW+1];
	logic [QW-1:0] dv_quo  [QW+1];
	logic          dv_zero [QW+1];

	assign dv_v[0]    = oc_v[MAX_OCTAVES];
	assign dv_rem[0]  = {oc_fin[MAX_OCTAVES], 16'd0};
	assign dv_den[0]  = {oc_amp[MAX_OCTAVES], 8'd0};
	assign dv_quo[0]  = '0;
	assign dv_zero[0] = oc_amp[MAX_OCTAVES] == '0;

	for (genvar b = 0; b < QW; b++) begin : g_div
		fvn_div_cell #(.FRAC_BITS(F), .QBIT(QW-1-b)) u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (dv_v[b]),
			.in_rem   (dv_rem[b]),
			.in_den   (dv_den[b]),
			.in_quo   (dv_quo[b]),
			.in_zero  (dv_zero[b]),
			.out_valid(dv_v[b+1]),
			.out_rem  (dv_rem[b+1]),
			.out_den  (dv_den[b+1]),
			.out_quo  (dv_quo[b+1]),
			.out_zero (dv_zero[b+1])
		);
	end

	// output register plus skid entry
	logic [QW-1:0] result;
	logic [QW-1:0] out_q, skid_q;
	logic          push, pop;

	assign result = dv_zero[QW] ? '0 : dv_quo[QW];
	assign push = en && dv_v[QW];
	assign pop = out_valid_q && noise.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_q <= result;
			end else begin
				out_q <= result;
			end
		end
	end

	assign noise.valid = out_valid_q;
	assign noise.noise_value = out_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held with empty output register");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !push)
		else $error("result pushed into a full output buffer");

	a_hold_unpopped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !noise.ready |=> out_valid_q && $stable(out_q))
		else $error("waiting result dropped or changed");

	a_result_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q <= fvn_pkg::OUT_MAX)
		else $error("noise value above its normalized bound");
endmodule

[dv/fractal_value_noise_2d_tb.sv]
// Self-checking testbench for the fractal value noise block: directed table and register cases, then random points.
module fractal_value_noise_2d_tb;

	localparam int LATENCY = 2 + 4 * fvn_pkg::MAX_OCTAVES_DEF + 16;
	localparam longint CYCLE_LIMIT = 400000;
	localparam int FB = fvn_pkg::FRAC_BITS_DEF;
	localparam logic [fvn_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

	typedef struct {
		logic [fvn_pkg::COORD_W-1:0] x;
		logic [fvn_pkg::COORD_W-1:0] y;
		logic                        check_fixed;
		logic [fvn_pkg::OUT_W-1:0]   fixed_value;
	} point_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [fvn_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [fvn_pkg::CFG_DATA_W-1:0] cfg_data;

	fvn_point_if point ();
	fvn_noise_if noise ();

	fractal_value_noise_2d dut (
		.clk(clk), .arst_n(arst_n), .point(point.sink), .noise(noise.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow copy of the registers
	logic [fvn_pkg::FREQ_W-1:0]    freq_q;
	logic [fvn_pkg::OCT_CNT_W-1:0] octaves_q;
	logic [fvn_pkg::SEED_W-1:0]    seed_q;

	logic [fvn_pkg::OUT_W-1:0] noise_pending[$];
	int  mismatches = 0;
	longint cycles = 0;
	int  send_idle_pct;
	int  recv_idle_pct;
	bit  recv_hold;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] smooth_weight(input logic [63:0] f);
		logic [63:0] f2;
		f2 = (f * f) >> FB;
		return (f2 * (3 * (64'd1 << FB) - 2 * f)) >> FB;
	endfunction

	function automatic logic [63:0] mix(input logic [63:0] a, input logic [63:0] b,
			input logic [63:0] w);
		return (a * ((64'd1 << FB) - w) + b * w) >> FB;
	endfunction

	function automatic logic [63:0] corner(input logic [7:0] ix, input logic [7:0] iy);
		logic [7:0] row;
		logic [7:0] sum_y;
		logic [7:0] sum_x;
		sum_y = iy + seed_q;
		row = fvn_pkg::PERM[sum_y];
		sum_x = row + ix;
		return 64'(fvn_pkg::PERM[sum_x]) << FB;
	endfunction

	function automatic logic [fvn_pkg::OUT_W-1:0] noise_of(
			input logic [fvn_pkg::COORD_W-1:0] cx, input logic [fvn_pkg::COORD_W-1:0] cy);
		logic [63:0] px, py, fin, amp, wx, wy, lo, hi;
		logic [7:0] ix, iy;
		int depth;
		depth = (octaves_q > fvn_pkg::MAX_OCTAVES_DEF) ? fvn_pkg::MAX_OCTAVES_DEF
			: int'(octaves_q);
		if (depth == 0) return '0;
		px = (64'(cx) * 64'(freq_q)) >> 16;
		py = (64'(cy) * 64'(freq_q)) >> 16;
		fin = 0;
		amp = 0;
		for (int k = 0; k < depth; k++) begin
			ix = px[FB +: 8];
			iy = py[FB +: 8];
			wx = smooth_weight(px & ((64'd1 << FB) - 1));
			wy = smooth_weight(py & ((64'd1 << FB) - 1));
			lo = mix(corner(ix, iy), corner(ix + 8'd1, iy), wx);
			hi = mix(corner(ix, iy + 8'd1), corner(ix + 8'd1, iy + 8'd1), wx);
			fin += mix(lo, hi, wy) >> k;
			amp += (64'd1 << FB) >> k;
			px = px << 1;
			py = py << 1;
		end
		return fvn_pkg::OUT_W'((fin << 16) / (amp << 8));
	endfunction

	task automatic write_reg(input logic [fvn_pkg::CFG_IDX_W-1:0] idx,
			input logic [fvn_pkg::CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			fvn_pkg::REG_FREQUENCY:    freq_q = val[fvn_pkg::FREQ_W-1:0];
			fvn_pkg::REG_OCTAVE_COUNT: octaves_q = val[fvn_pkg::OCT_CNT_W-1:0];
			fvn_pkg::REG_SEED:         seed_q = val[fvn_pkg::SEED_W-1:0];
			default: ;
		endcase
	endtask

	// Hold valid across back-to-back beats; drop it only on an idle cycle
	task automatic send_point(input logic [fvn_pkg::COORD_W-1:0] x,
			input logic [fvn_pkg::COORD_W-1:0] y,
			input logic check_fixed, input logic [fvn_pkg::OUT_W-1:0] fixed_value);
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
			point.valid <= 1'b0;
			@(posedge clk);
		end
		point.valid <= 1'b1;
		point.coord_x <= x;
		point.coord_y <= y;
		@(posedge clk);
		while (!point.ready) @(posedge clk);
		noise_pending.push_back(check_fixed ? fixed_value : noise_of(x, y));
	endtask

	task automatic drain;
		point.valid <= 1'b0;
		while (noise_pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	task automatic random_points(input int n);
		logic [fvn_pkg::COORD_W-1:0] x, y;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(3, 0))
				0: begin x = $urandom(); y = $urandom(); end
				1: begin
					x = $urandom_range(32'h00FF_FFFF, 0);
					y = $urandom_range(32'h00FF_FFFF, 0);
				end
				2: begin x = {16'($urandom_range(255, 0)), 16'hFFFF}; y = $urandom(); end
				default: begin x = $urandom(); y = {16'(255 - $urandom_range(1, 0)), 16'(0)}; end
			endcase
			send_point(x, y, 1'b0, '0);
		end
	endtask

	// Receiver: random stalls plus one long hold to back up the pipeline
	always @(posedge clk) begin
		if (recv_hold) noise.ready <= 1'b0;
		else noise.ready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && noise.valid && noise.ready) begin
			if (noise_pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected noise beat %0d", noise.noise_value);
			end else begin
				if (noise.noise_value !== noise_pending[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("noise mismatch: expected %0d got %0d",
							noise_pending[0], noise.noise_value);
				end
				void'(noise_pending.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("fractal_value_noise_2d_tb: errors");
			$finish;
		end
	end

	initial begin
		point_row_t rows[$];
		recv_hold = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		point.valid = 1'b0;
		point.coord_x = '0;
		point.coord_y = '0;
		freq_q = fvn_pkg::FREQ_RESET;
		octaves_q = fvn_pkg::OCT_RESET;
		seed_q = fvn_pkg::SEED_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Origin at reset: every octave lands on lattice (0,0), byte 42 -> 42*256
		rows.push_back('{32'h0, 32'h0, 1'b1, 16'd10752});
		rows.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0});
		rows.push_back('{32'hFFFF_FFFF, 32'h0, 1'b0, '0});
		rows.push_back('{32'h0, 32'hFFFF_FFFF, 1'b0, '0});
		rows.push_back('{32'h8000_0000, 32'h0001_0000, 1'b0, '0});
		rows.push_back('{32'h00FF_8000, 32'h00FF_FFFF, 1'b0, '0});
		rows.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0});
		foreach (rows[i])
			send_point(rows[i].x, rows[i].y, rows[i].check_fixed, rows[i].fixed_value);
		drain();

		// Zero depth gives zero; corner wrap at index 255 with unit frequency
		write_reg(fvn_pkg::REG_OCTAVE_COUNT, 24'd0);
		send_point(32'hFFFF_FFFF, 32'h1234_5678, 1'b1, '0);
		drain();
		write_reg(fvn_pkg::REG_FREQUENCY, 24'h01_0000);
		write_reg(fvn_pkg::REG_OCTAVE_COUNT, 24'd1);
		write_reg(fvn_pkg::REG_SEED, 24'd255);
		write_reg(REG_UNMAPPED, 24'hFF_FFFF);
		send_point(32'h00FF_8000, 32'h00FF_C000, 1'b0, '0);
		send_point(32'h00FF_0000, 32'h00FF_0000, 1'b0, '0);
		drain();
		// Depth above the limit saturates
		write_reg(fvn_pkg::REG_OCTAVE_COUNT, 24'd63);
		write_reg(fvn_pkg::REG_FREQUENCY, 24'hFF_FFFF);
		send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0);
		send_point(32'h0000_0001, 32'h0000_0001, 1'b0, '0);
		drain();

		// Random phase one: sender idles little, receiver often, one long hold
		send_idle_pct = 26;
		recv_idle_pct = 59;
		write_reg(fvn_pkg::REG_FREQUENCY, 24'd3277);
		write_reg(fvn_pkg::REG_OCTAVE_COUNT, 24'd32);
		write_reg(fvn_pkg::REG_SEED, 24'($urandom_range(255, 0)));
		fork
			begin
				recv_hold = 1'b1;
				repeat (LATENCY * 3) @(posedge clk);
				recv_hold = 1'b0;
			end
			random_points(300);
		join
		drain();

		send_idle_pct = 59;
		recv_idle_pct = 26;
		write_reg(fvn_pkg::REG_FREQUENCY, 24'h00_0000);
		write_reg(fvn_pkg::REG_OCTAVE_COUNT, 24'd1);
		random_points(50);
		drain();
		write_reg(fvn_pkg::REG_FREQUENCY, 24'($urandom()));
		write_reg(fvn_pkg::REG_OCTAVE_COUNT, 24'($urandom_range(32, 1)));
		write_reg(fvn_pkg::REG_SEED, 24'($urandom_range(255, 0)));
		random_points(250);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(fvn_pkg::REG_FREQUENCY, 24'h01_0000);
		write_reg(fvn_pkg::REG_OCTAVE_COUNT, 24'd32);
		write_reg(fvn_pkg::REG_SEED, 24'd255);
		random_points(300);
		drain();

		if (mismatches == 0 && noise_pending.size() == 0) begin
			$display("fractal_value_noise_2d_tb: clean");
		end else begin
			$display("fractal_value_noise_2d_tb: errors");
		end
		$finish;
	end

endmodule

[filelist.f]
design/fvn_pkg.sv
design/fvn_if.sv
design/fvn_octave_cell.sv
design/fvn_div_cell.sv
design/fractal_value_noise_2d.sv
dv/fractal_value_noise_2d_tb.sv
